// ----- src/audio_capture_ring_buffer_top_assert.svh -----
// Assertion macros used by the capture buffer checker.
// Depends on a clock named clock and an active-high reset named reset in scope.
`ifndef AUDIO_CAPTURE_RING_BUFFER_TOP_ASSERT_SVH
`define AUDIO_CAPTURE_RING_BUFFER_TOP_ASSERT_SVH

// same-cycle implication
`define ACRB_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ACRB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/acrb_pkg.sv -----
// Shared codes and types of the audio capture ring buffer.
// No dependencies.
`timescale 1ns / 1ps

package acrb_pkg;

   localparam logic [2:0] ACT_BEGIN  = 3'd0;
   localparam logic [2:0] ACT_SAMPLE = 3'd1;
   localparam logic [2:0] ACT_POP    = 3'd2;
   localparam logic [2:0] ACT_PEAK   = 3'd3;
   localparam logic [2:0] ACT_STATUS = 3'd4;

   localparam logic [1:0] KIND_SAMPLE = 2'd0;
   localparam logic [1:0] KIND_EMPTY  = 2'd1;
   localparam logic [1:0] KIND_PEAK   = 2'd2;
   localparam logic [1:0] KIND_STATUS = 2'd3;

   localparam logic [0:0] CSR_CHANNELS  = 1'd0;
   localparam logic [0:0] CSR_RING_SIZE = 1'd1;

   localparam logic [30:0] INF_BITS = 31'h7F800000;

   typedef struct packed {
      logic        valid;
      logic        clear;
      logic [30:0] mag;
   } peak_op_type;

endpackage

// ----- src/audio_capture_ring_buffer_top.sv -----
// Audio capture ring buffer with per-channel peak meter, top level.
// Depends on acrb_pkg and acrb_peak.
`timescale 1ns / 1ps

// Timing as seen at the ports. A word is taken when start is high and busy is
// low. Samples are taken one per cycle while busy is low. A block begin holds
// busy for one cycle while the product of frames and channels is checked
// against free room. A pop returns its words on consecutive cycles from the
// cycle after it is taken, one per cycle from the single read port of the
// sample memory, busy high until the last word is read; an empty pop answers
// the next cycle. A status read answers the next cycle. A peak read answers
// after the peak memory read-clear, with busy high for one cycle. rsp_valid
// marks each result for exactly one cycle and the receiver cannot stall it.
// No clearing pass follows reset: peak entries carry valid bits.
module audio_capture_ring_buffer_top #(
   parameter int RING_DEPTH   = 65536,
   parameter int MAX_CHANNELS = 32,
   parameter int MAX_POP      = 64,
   parameter int MAX_FRAMES   = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_action,
   input  logic [12:0] req_frame_count,
   input  logic [31:0] req_sample_bits,
   input  logic [6:0]  req_max_count,
   input  logic [4:0]  req_channel,
   output logic        rsp_valid,
   output logic [1:0]  rsp_kind,
   output logic [31:0] rsp_sample_bits_res,
   output logic        rsp_last,
   output logic [30:0] rsp_peak_bits,
   output logic [47:0] rsp_frames_total,
   output logic [15:0] rsp_overrun_count,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [16:0] csr_wdata
);

   localparam int PTR_W    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int SIZE_W   = $clog2(RING_DEPTH + 1);
   localparam int CH_W     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int CC_W     = $clog2(MAX_CHANNELS + 1);
   localparam int FR_W     = $clog2(MAX_FRAMES + 1);
   localparam int TOT_W    = FR_W + CC_W;
   localparam int POP_W    = $clog2(MAX_POP + 1);
   localparam int UW       = PTR_W + 1;
   localparam int SUM_W    = ((TOT_W > UW) ? TOT_W : UW) + 1;
   localparam int RS_RESET = (RING_DEPTH < 65536) ? RING_DEPTH : 65536;
   localparam int CC_RESET = (MAX_CHANNELS < 2) ? MAX_CHANNELS : 2;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_BEGIN = 2'd1;
   localparam logic [1:0] S_PEAK  = 2'd2;
   localparam logic [1:0] S_POP   = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [CC_W-1:0]   cc_ff, cc_in;
   logic [SIZE_W-1:0] rs_ff, rs_in;
   logic [PTR_W-1:0]  rs_last_ff, rs_last_in;
   logic [PTR_W-1:0]  fill_ff, fill_in;
   logic [PTR_W-1:0]  pub_ff, pub_in;
   logic [PTR_W-1:0]  drain_ff, drain_in;
   logic [CH_W-1:0]   cpos_ff, cpos_in;
   logic [TOT_W-1:0]  remain_ff, remain_in;
   logic              admit_ff, admit_in;
   logic [FR_W-1:0]   bframes_ff, bframes_in;
   logic [47:0]       ftotal_ff, ftotal_in;
   logic [15:0]       ovr_ff, ovr_in;
   logic [PTR_W-1:0]  used_ff, used_in;
   logic [TOT_W-1:0]  total_ff, total_in;
   logic [POP_W-1:0]  popcnt_ff, popcnt_in;
   logic              peak_oor_ff, peak_oor_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_kind_ff, rsp_kind_in;
   logic              rsp_last_ff, rsp_last_in;
   logic [30:0]       rsp_peak_ff, rsp_peak_in;
   logic [47:0]       rsp_frames_ff, rsp_frames_in;
   logic [15:0]       rsp_ovr_ff, rsp_ovr_in;

   logic [31:0]       ring_mem [RING_DEPTH];
   logic [31:0]       ring_q_ff;
   logic              ring_we;
   logic              ring_re;

   acrb_pkg::peak_op_type peak_op;
   logic [CH_W-1:0]   peak_addr;
   logic [30:0]       peak_cur;

   logic [31:0]       cc_sat, rs_sat, rs_m1, fr_sat, mc_sat, mc_m1, ch_w;
   logic              ch_ok;
   logic [FR_W-1:0]   frames;
   logic [TOT_W-1:0]  prod;
   logic [UW-1:0]     pub_x, drain_x, rs_x, used_x;
   logic [SUM_W-1:0]  adm_sum;
   logic              over;
   logic [48:0]       ft_sum;
   logic [47:0]       ftotal_sat;
   logic [PTR_W-1:0]  fill_wrap, drain_wrap;
   logic [CC_W-1:0]   cpos_nx;
   logic [CH_W-1:0]   cpos_wrap;
   logic [30:0]       mag;
   logic              pop_last;

   acrb_peak #(
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_peak (
      .clock     (clock),
      .reset     (reset),
      .op        (peak_op),
      .op_addr   (peak_addr),
      .cur_value (peak_cur)
   );

   always_comb begin
      cc_sat = {26'd0, csr_wdata[5:0]};
      if (cc_sat < 32'd1) begin
         cc_sat = 32'd1;
      end else if (cc_sat > 32'(MAX_CHANNELS)) begin
         cc_sat = 32'(MAX_CHANNELS);
      end
      rs_sat = {15'd0, csr_wdata};
      if (rs_sat < 32'd2) begin
         rs_sat = 32'd2;
      end else if (rs_sat > 32'(RING_DEPTH)) begin
         rs_sat = 32'(RING_DEPTH);
      end
      rs_m1 = rs_sat - 32'd1;

      fr_sat = {19'd0, req_frame_count};
      if (fr_sat > 32'(MAX_FRAMES)) begin
         fr_sat = 32'(MAX_FRAMES);
      end
      frames = fr_sat[FR_W-1:0];
      prod   = {{CC_W{1'b0}}, frames} * {{FR_W{1'b0}}, cc_ff};

      mc_sat = {25'd0, req_max_count};
      if (mc_sat == 32'd0) begin
         mc_sat = 32'd1;
      end else if (mc_sat > 32'(MAX_POP)) begin
         mc_sat = 32'(MAX_POP);
      end
      mc_m1 = mc_sat - 32'd1;

      ch_w  = {27'd0, req_channel};
      ch_ok = ch_w < 32'(MAX_CHANNELS);

      pub_x   = {1'b0, pub_ff};
      drain_x = {1'b0, drain_ff};
      rs_x    = UW'(rs_ff);
      used_x  = (pub_ff >= drain_ff) ? (pub_x - drain_x) : (pub_x + rs_x - drain_x);

      adm_sum = SUM_W'(used_ff) + SUM_W'(total_ff);
      over    = adm_sum >= SUM_W'(rs_ff);

      ft_sum     = {1'b0, ftotal_ff} + 49'(bframes_ff);
      ftotal_sat = ft_sum[48] ? '1 : ft_sum[47:0];

      fill_wrap  = (fill_ff == rs_last_ff) ? '0 : fill_ff + 1'b1;
      drain_wrap = (drain_ff == rs_last_ff) ? '0 : drain_ff + 1'b1;
      cpos_nx    = CC_W'(cpos_ff) + CC_W'(1);
      cpos_wrap  = (cpos_nx == cc_ff) ? '0 : cpos_nx[CH_W-1:0];
      mag        = req_sample_bits[30:0];
   end

   always_comb begin
      state_in    = state_ff;
      cc_in       = cc_ff;
      rs_in       = rs_ff;
      rs_last_in  = rs_last_ff;
      fill_in     = fill_ff;
      pub_in      = pub_ff;
      drain_in    = drain_ff;
      cpos_in     = cpos_ff;
      remain_in   = remain_ff;
      admit_in    = admit_ff;
      bframes_in  = bframes_ff;
      ftotal_in   = ftotal_ff;
      ovr_in      = ovr_ff;
      used_in     = used_ff;
      total_in    = total_ff;
      popcnt_in   = popcnt_ff;
      peak_oor_in = peak_oor_ff;

      rsp_valid_in  = 1'b0;
      rsp_kind_in   = acrb_pkg::KIND_SAMPLE;
      rsp_last_in   = 1'b0;
      rsp_peak_in   = '0;
      rsp_frames_in = '0;
      rsp_ovr_in    = '0;

      ring_we   = 1'b0;
      ring_re   = 1'b0;
      peak_op   = '0;
      peak_addr = cpos_ff;
      pop_last  = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (req_action)
                  acrb_pkg::ACT_BEGIN: begin
                     fill_in    = pub_ff;
                     cpos_in    = '0;
                     remain_in  = '0;
                     admit_in   = 1'b0;
                     bframes_in = frames;
                     used_in    = used_x[PTR_W-1:0];
                     total_in   = prod;
                     state_in   = S_BEGIN;
                  end
                  acrb_pkg::ACT_SAMPLE: begin
                     if (remain_ff != '0) begin
                        peak_op.valid = mag <= acrb_pkg::INF_BITS;
                        peak_op.mag   = mag;
                        if (admit_ff) begin
                           ring_we = 1'b1;
                           fill_in = fill_wrap;
                        end
                        cpos_in   = cpos_wrap;
                        remain_in = remain_ff - 1'b1;
                        if (remain_ff == TOT_W'(1)) begin
                           if (admit_ff) begin
                              pub_in    = fill_wrap;
                              ftotal_in = ftotal_sat;
                           end
                           admit_in   = 1'b0;
                           bframes_in = '0;
                        end
                     end
                  end
                  acrb_pkg::ACT_POP: begin
                     rsp_valid_in = 1'b1;
                     rsp_last_in  = 1'b1;
                     if (pub_ff == drain_ff) begin
                        rsp_kind_in = acrb_pkg::KIND_EMPTY;
                     end else begin
                        ring_re     = 1'b1;
                        drain_in    = drain_wrap;
                        pop_last    = (mc_sat == 32'd1) || (drain_wrap == pub_ff);
                        rsp_last_in = pop_last;
                        popcnt_in   = mc_m1[POP_W-1:0];
                        if (!pop_last) begin
                           state_in = S_POP;
                        end
                     end
                  end
                  acrb_pkg::ACT_PEAK: begin
                     peak_op.valid = ch_ok;
                     peak_op.clear = 1'b1;
                     peak_addr     = ch_w[CH_W-1:0];
                     peak_oor_in   = !ch_ok;
                     state_in      = S_PEAK;
                  end
                  acrb_pkg::ACT_STATUS: begin
                     rsp_valid_in  = 1'b1;
                     rsp_kind_in   = acrb_pkg::KIND_STATUS;
                     rsp_last_in   = 1'b1;
                     rsp_frames_in = ftotal_ff;
                     rsp_ovr_in    = ovr_ff;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_BEGIN: begin
            remain_in = total_ff;
            admit_in  = !over && (total_ff != '0);
            if (over && (ovr_ff != 16'hFFFF)) begin
               ovr_in = ovr_ff + 16'd1;
            end
            if (total_ff == '0) begin
               bframes_in = '0;
            end
            state_in = S_IDLE;
         end
         S_PEAK: begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = acrb_pkg::KIND_PEAK;
            rsp_last_in  = 1'b1;
            rsp_peak_in  = peak_oor_ff ? '0 : peak_cur;
            state_in     = S_IDLE;
         end
         S_POP: begin
            ring_re      = 1'b1;
            drain_in     = drain_wrap;
            pop_last     = (popcnt_ff == POP_W'(1)) || (drain_wrap == pub_ff);
            popcnt_in    = popcnt_ff - 1'b1;
            rsp_valid_in = 1'b1;
            rsp_last_in  = pop_last;
            if (pop_last) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_we) begin
         case (csr_index)
            acrb_pkg::CSR_CHANNELS: begin
               cc_in   = cc_sat[CC_W-1:0];
               cpos_in = '0;
            end
            acrb_pkg::CSR_RING_SIZE: begin
               rs_in      = rs_sat[SIZE_W-1:0];
               rs_last_in = rs_m1[PTR_W-1:0];
               fill_in    = '0;
               pub_in     = '0;
               drain_in   = '0;
               remain_in  = '0;
               admit_in   = 1'b0;
               bframes_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[fill_ff] <= req_sample_bits;
      end
      ring_q_ff <= ring_re ? ring_mem[drain_ff] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cc_ff        <= CC_W'(CC_RESET);
         rs_ff        <= SIZE_W'(RS_RESET);
         rs_last_ff   <= PTR_W'(RS_RESET - 1);
         fill_ff      <= '0;
         pub_ff       <= '0;
         drain_ff     <= '0;
         cpos_ff      <= '0;
         remain_ff    <= '0;
         admit_ff     <= 1'b0;
         bframes_ff   <= '0;
         ftotal_ff    <= '0;
         ovr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cc_ff        <= cc_in;
         rs_ff        <= rs_in;
         rs_last_ff   <= rs_last_in;
         fill_ff      <= fill_in;
         pub_ff       <= pub_in;
         drain_ff     <= drain_in;
         cpos_ff      <= cpos_in;
         remain_ff    <= remain_in;
         admit_ff     <= admit_in;
         bframes_ff   <= bframes_in;
         ftotal_ff    <= ftotal_in;
         ovr_ff       <= ovr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      used_ff       <= used_in;
      total_ff      <= total_in;
      popcnt_ff     <= popcnt_in;
      peak_oor_ff   <= peak_oor_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_peak_ff   <= rsp_peak_in;
      rsp_frames_ff <= rsp_frames_in;
      rsp_ovr_ff    <= rsp_ovr_in;
   end

   assign busy                = (state_ff != S_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_kind            = rsp_kind_ff;
   assign rsp_sample_bits_res = ring_q_ff;
   assign rsp_last            = rsp_last_ff;
   assign rsp_peak_bits       = rsp_peak_ff;
   assign rsp_frames_total    = rsp_frames_ff;
   assign rsp_overrun_count   = rsp_ovr_ff;

endmodule

// ----- src/acrb_peak.sv -----
// Per-channel peak meter: read-modify-write on a small synchronous memory.
// Depends on acrb_pkg (peak_op_type).
`timescale 1ns / 1ps

module acrb_peak #(
   parameter int MAX_CHANNELS = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  acrb_pkg::peak_op_type      op,
   input  logic [((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1)-1:0] op_addr,
   output logic [30:0]                cur_value
);

   localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

   logic [30:0]             peak_mem [MAX_CHANNELS];
   logic [30:0]             peak_q_ff;
   logic                    qv_ff, qv_in;
   logic [MAX_CHANNELS-1:0] vld_ff, vld_in;
   logic                    s2_vld_ff, s2_vld_in;
   logic                    s2_clr_ff, s2_clr_in;
   logic [30:0]             s2_mag_ff, s2_mag_in;
   logic [CH_W-1:0]         s2_addr_ff, s2_addr_in;
   logic                    lw_vld_ff, lw_vld_in;
   logic [CH_W-1:0]         lw_addr_ff, lw_addr_in;
   logic [30:0]             lw_data_ff, lw_data_in;
   logic [30:0]             stored;
   logic                    wr_en;
   logic [30:0]             wr_data;

   // forward the write that landed on the same edge as this read
   always_comb begin
      stored    = qv_ff ? peak_q_ff : '0;
      cur_value = (lw_vld_ff && (lw_addr_ff == s2_addr_ff)) ? lw_data_ff : stored;
      wr_en     = s2_vld_ff && (s2_clr_ff || (s2_mag_ff > cur_value));
      wr_data   = s2_clr_ff ? '0 : s2_mag_ff;
      vld_in    = vld_ff;
      if (wr_en) begin
         vld_in[s2_addr_ff] = 1'b1;
      end
      qv_in      = vld_ff[op_addr];
      s2_vld_in  = op.valid;
      s2_clr_in  = op.clear;
      s2_mag_in  = op.mag;
      s2_addr_in = op_addr;
      lw_vld_in  = wr_en;
      lw_addr_in = s2_addr_ff;
      lw_data_in = wr_data;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         peak_mem[s2_addr_ff] <= wr_data;
      end
      peak_q_ff <= peak_mem[op_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         s2_vld_ff <= 1'b0;
         lw_vld_ff <= 1'b0;
      end else begin
         vld_ff    <= vld_in;
         s2_vld_ff <= s2_vld_in;
         lw_vld_ff <= lw_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      qv_ff      <= qv_in;
      s2_clr_ff  <= s2_clr_in;
      s2_mag_ff  <= s2_mag_in;
      s2_addr_ff <= s2_addr_in;
      lw_addr_ff <= lw_addr_in;
      lw_data_ff <= lw_data_in;
   end

endmodule

// ----- src/acrb_checker.sv -----
// Port-level checks of the capture buffer, bound to the top level.
// Depends on acrb_pkg and audio_capture_ring_buffer_top_assert.svh.
`timescale 1ns / 1ps
`include "audio_capture_ring_buffer_top_assert.svh"

module acrb_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [2:0]  req_action,
   input logic        rsp_valid,
   input logic [1:0]  rsp_kind,
   input logic        rsp_last,
   input logic [31:0] rsp_sample_bits_res
);

   `ACRB_ASSERT_NOW(a_single_word, rsp_valid && (rsp_kind != acrb_pkg::KIND_SAMPLE), rsp_last && (rsp_sample_bits_res == 32'd0), "non-sample word must be last with zero sample")
   `ACRB_ASSERT_NEXT(a_pop_run, rsp_valid && !rsp_last, rsp_valid && (rsp_kind == acrb_pkg::KIND_SAMPLE), "pop run broken before last word")
   `ACRB_ASSERT_NEXT(a_status_next, start && !busy && (req_action == acrb_pkg::ACT_STATUS), rsp_valid && (rsp_kind == acrb_pkg::KIND_STATUS) && rsp_last, "status word missing")
   `ACRB_ASSERT_NEXT(a_peak_lat, start && !busy && (req_action == acrb_pkg::ACT_PEAK), busy && !rsp_valid ##1 rsp_valid && (rsp_kind == acrb_pkg::KIND_PEAK), "peak word latency wrong")

endmodule

bind audio_capture_ring_buffer_top acrb_checker u_acrb_checker (.*);

// ----- verif/tb.sv -----
// Self-checking testbench for audio_capture_ring_buffer_top: a directed table,
// then channel/ring-size phases of random block traffic and an overrun pile-up.
// Depends on acrb_pkg and the RTL top; results are checked against a local predictor.
`timescale 1ns / 1ps

module tb;
   import acrb_pkg::*;

   localparam int unsigned RING_DEPTH = 65536;
   localparam int unsigned MAX_CH = 32;
   localparam int unsigned MAX_POP = 64;
   localparam int unsigned MAX_FRAMES = 4096;
   localparam longint unsigned FRAME_SAT = 64'hFFFF_FFFF_FFFF;
   localparam int unsigned OVR_SAT = 65535;
   localparam logic [2:0] ACT_RESERVED_LO = 3'd5;
   localparam logic [2:0] ACT_RESERVED_HI = 3'd7;
   localparam int SETTLE = 16;
   localparam int WATCHDOG_CYCLES = 2000;
   localparam int DIR_ROWS = 25;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] smp;
      logic        last;
      logic [30:0] peak;
      logic [47:0] frames;
      logic [15:0] ovr;
   } capture_result_t;

   typedef struct {
      logic [2:0]  action;
      logic [12:0] frames;
      logic [31:0] bits;
      logic [6:0]  max_count;
      logic [4:0]  chan;
      bit          typed;
      logic [1:0]  wkind;
      logic [30:0] wpeak;
      logic [47:0] wframes;
      logic [15:0] wovr;
   } stim_row_t;

   logic        clock;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_action = '0;
   logic [12:0] req_frame_count = '0;
   logic [31:0] req_sample_bits = '0;
   logic [6:0]  req_max_count = '0;
   logic [4:0]  req_channel = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_kind;
   logic [31:0] rsp_sample_bits_res;
   logic        rsp_last;
   logic [30:0] rsp_peak_bits;
   logic [47:0] rsp_frames_total;
   logic [15:0] rsp_overrun_count;
   logic        csr_we = 1'b0;
   logic [0:0]  csr_index = '0;
   logic [16:0] csr_wdata = '0;

   // typed expectation travels with the word it belongs to
   bit              typed_pend = 1'b0;
   capture_result_t typed_want = '0;

   // predictor state
   int unsigned     chan_count, ring_len, fill_ptr, pub_ptr, drain_ptr;
   int unsigned     chan_pos, samples_left, blk_frames, overruns;
   bit              blk_admitted;
   longint unsigned frames_admitted;
   bit [30:0]       peak_mag [MAX_CH];
   bit [31:0]       ring_mem [RING_DEPTH];

   capture_result_t step_results[$];
   capture_result_t pending_results[$];
   int              mismatches = 0;
   int              idle_cycles = 0;
   int              burst_left = 0;

   stim_row_t dir_tab [DIR_ROWS] = '{
      '{ACT_STATUS, 13'd0, 32'd0, 7'd1, 5'd0, 1'b1, KIND_STATUS, 31'd0, 48'd0, 16'd0},
      '{ACT_POP, 13'd0, 32'd0, 7'd1, 5'd0, 1'b1, KIND_EMPTY, 31'd0, 48'd0, 16'd0},
      '{ACT_PEAK, 13'd0, 32'd0, 7'd1, 5'd0, 1'b1, KIND_PEAK, 31'd0, 48'd0, 16'd0},
      '{ACT_PEAK, 13'd0, 32'd0, 7'd1, 5'd31, 1'b1, KIND_PEAK, 31'd0, 48'd0, 16'd0},
      '{ACT_BEGIN, 13'd2, 32'd0, 7'd1, 5'd0, 1'b0, KIND_SAMPLE, 31'd0, 48'd0, 16'd0},
      '{ACT_SAMPLE, 13'd0, 32'h8000_0000, 7'd1, 5'd0, 1'b0, KIND_SAMPLE, 31'd0, 48'd0,
        16'd0},
      '{ACT_SAMPLE, 13'd0, 32'h7F80_0000, 7'd1, 5'd0, 1'b0, KIND_SAMPLE, 31'd0, 48'd0,
        16'd0},
      '{ACT_SAMPLE, 13'd0, 32'hFFFF_FFFF, 7'd1, 5'd0, 1'b0, KIND_SAMPLE, 31'd0, 48'd0,
        16'd0},
      '{ACT_SAMPLE, 13'd0, 32'hBF80_0000, 7'd1, 5'd0, 1'b0, KIND_SAMPLE, 31'd0, 48'd0,
        16'd0},
      '{ACT_SAMPLE, 13'd0, 32'h1234_5678, 7'd1, 5'd0, 1'b0, KIND_SAMPLE, 31'd0, 48'd0,
        16'd0},
      '{ACT_POP, 13'd0, 32'd0, 7'd0, 5'd0, 1'b0, KIND_SAMPLE, 31'd0, 48'd0, 16'd0},
      '{ACT_POP, 13'd0, 32'd0, 7'd127, 5'd0, 1'b0, KIND_SAMPLE, 31'd0, 48'd0, 16'd0},
      '{ACT_POP, 13'd0, 32'd0, 7'd64, 5'd0, 1'b1, KIND_EMPTY, 31'd0, 48'd0, 16'd0},
      '{ACT_PEAK, 13'd0, 32'd0, 7'd1, 5'd0, 1'b1, KIND_PEAK, 31'd0, 48'd0, 16'd0},
      '{ACT_PEAK, 13'd0, 32'd0, 7'd1, 5'd1, 1'b1, KIND_PEAK, 31'h7F80_0000, 48'd0, 16'd0},
      '{ACT_PEAK, 13'd0, 32'd0, 7'd1, 5'd1, 1'b1, KIND_PEAK, 31'd0, 48'd0, 16'd0},
      '{ACT_BEGIN, 13'd0, 32'd0, 7'd1, 5'd0, 1'b0, KIND_SAMPLE, 31'd0, 48'd0, 16'd0},
      '{ACT_STATUS, 13'd0, 32'd0, 7'd1, 5'd0, 1'b1, KIND_STATUS, 31'd0, 48'd2, 16'd0},
      '{ACT_BEGIN, 13'h1FFF, 32'd0, 7'd1, 5'd0, 1'b0, KIND_SAMPLE, 31'd0, 48'd0, 16'd0},
      '{ACT_BEGIN, 13'd1, 32'd0, 7'd1, 5'd0, 1'b0, KIND_SAMPLE, 31'd0, 48'd0, 16'd0},
      '{ACT_SAMPLE, 13'd0, 32'h0000_0001, 7'd1, 5'd0, 1'b0, KIND_SAMPLE, 31'd0, 48'd0,
        16'd0},
      '{ACT_SAMPLE, 13'd0, 32'h7F7F_FFFF, 7'd1, 5'd0, 1'b0, KIND_SAMPLE, 31'd0, 48'd0,
        16'd0},
      '{ACT_RESERVED_LO, 13'h1FFF, 32'hFFFF_FFFF, 7'h7F, 5'd31, 1'b0, KIND_SAMPLE, 31'd0,
        48'd0, 16'd0},
      '{ACT_STATUS, 13'd0, 32'd0, 7'd1, 5'd0, 1'b0, KIND_SAMPLE, 31'd0, 48'd0, 16'd0},
      '{ACT_POP, 13'd0, 32'd0, 7'd64, 5'd0, 1'b0, KIND_SAMPLE, 31'd0, 48'd0, 16'd0}
   };

   int unsigned phase_chans [6] = '{0, 63, 3, 32, 1, 2};
   int unsigned phase_ring [6] = '{0, 131071, 37, 70, 65536, 16};
   int unsigned phase_pop [6] = '{30, 10, 25, 20, 35, 15};

   audio_capture_ring_buffer_top i_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_action          (req_action),
      .req_frame_count     (req_frame_count),
      .req_sample_bits     (req_sample_bits),
      .req_max_count       (req_max_count),
      .req_channel         (req_channel),
      .rsp_valid           (rsp_valid),
      .rsp_kind            (rsp_kind),
      .rsp_sample_bits_res (rsp_sample_bits_res),
      .rsp_last            (rsp_last),
      .rsp_peak_bits       (rsp_peak_bits),
      .rsp_frames_total    (rsp_frames_total),
      .rsp_overrun_count   (rsp_overrun_count),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int unsigned ring_advance(input int unsigned p);
      return (p + 1 >= ring_len) ? 0 : p + 1;
   endfunction

   function automatic void close_block();
      if (blk_admitted) begin
         pub_ptr = fill_ptr;
         frames_admitted += blk_frames;
         if (frames_admitted > FRAME_SAT) frames_admitted = FRAME_SAT;
      end
      blk_admitted = 1'b0;
      blk_frames = 0;
   endfunction

   function automatic void buffer_reset();
      chan_count = 2;
      ring_len = RING_DEPTH;
      fill_ptr = 0;
      pub_ptr = 0;
      drain_ptr = 0;
      chan_pos = 0;
      samples_left = 0;
      blk_admitted = 1'b0;
      blk_frames = 0;
      frames_admitted = 0;
      overruns = 0;
      foreach (peak_mag[i]) peak_mag[i] = '0;
   endfunction

   function automatic void apply_csr(input logic [0:0] idx, input logic [16:0] data);
      int unsigned v;
      if (idx == CSR_CHANNELS) begin
         v = data[5:0];
         if (v < 1) v = 1;
         if (v > MAX_CH) v = MAX_CH;
         chan_count = v;
         chan_pos = 0;
      end else begin
         v = data;
         if (v < 2) v = 2;
         if (v > RING_DEPTH) v = RING_DEPTH;
         ring_len = v;
         fill_ptr = 0;
         pub_ptr = 0;
         drain_ptr = 0;
         samples_left = 0;
         blk_admitted = 1'b0;
         blk_frames = 0;
      end
   endfunction

   // results caused by one accepted word land in step_results
   function automatic void capture_step(input logic [2:0] act, input logic [12:0] fc,
                                        input logic [31:0] bits, input logic [6:0] mc,
                                        input logic [4:0] ch);
      int unsigned nf, total, used, lim, n;
      bit [30:0] mag;
      capture_result_t r;
      step_results.delete();
      r = '0;
      r.last = 1'b1;
      case (act)
         ACT_BEGIN: begin
            nf = (fc > MAX_FRAMES) ? MAX_FRAMES : fc;
            fill_ptr = pub_ptr;
            total = nf * chan_count;
            used = (pub_ptr + ring_len - drain_ptr) % ring_len;
            chan_pos = 0;
            samples_left = total;
            blk_frames = nf;
            if (used + total >= ring_len) begin
               blk_admitted = 1'b0;
               if (overruns < OVR_SAT) overruns++;
            end else begin
               blk_admitted = 1'b1;
            end
            if (total == 0) close_block();
         end
         ACT_SAMPLE: begin
            if (samples_left != 0) begin
               mag = bits[30:0];
               if (mag <= INF_BITS && mag > peak_mag[chan_pos]) peak_mag[chan_pos] = mag;
               if (blk_admitted) begin
                  ring_mem[fill_ptr] = bits;
                  fill_ptr = ring_advance(fill_ptr);
               end
               chan_pos++;
               if (chan_pos >= chan_count) chan_pos = 0;
               samples_left--;
               if (samples_left == 0) close_block();
            end
         end
         ACT_POP: begin
            lim = mc;
            if (lim < 1) lim = 1;
            if (lim > MAX_POP) lim = MAX_POP;
            used = (pub_ptr + ring_len - drain_ptr) % ring_len;
            if (used == 0) begin
               r.kind = KIND_EMPTY;
               step_results.push_back(r);
            end else begin
               n = (used < lim) ? used : lim;
               for (int i = 0; i < n; i++) begin
                  r.kind = KIND_SAMPLE;
                  r.smp = ring_mem[drain_ptr];
                  r.last = (i + 1 == n);
                  step_results.push_back(r);
                  drain_ptr = ring_advance(drain_ptr);
               end
            end
         end
         ACT_PEAK: begin
            r.kind = KIND_PEAK;
            r.peak = peak_mag[ch];
            peak_mag[ch] = '0;
            step_results.push_back(r);
         end
         ACT_STATUS: begin
            r.kind = KIND_STATUS;
            r.frames = frames_admitted[47:0];
            r.ovr = overruns[15:0];
            step_results.push_back(r);
         end
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [47:0] want,
                                  input logic [47:0] got);
      mismatches++;
      if (mismatches <= 100)
         $display("MISMATCH %s: expected %0h got %0h at %0t", what, want, got, $realtime);
   endtask

   always @(posedge clock) begin : monitor
      capture_result_t want;
      if (reset) begin
         buffer_reset();
         pending_results.delete();
         idle_cycles <= 0;
      end else begin
         if (rsp_valid) begin
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected result, kind", 48'd0, rsp_kind);
            end else begin
               want = pending_results.pop_front();
               if (rsp_kind !== want.kind) report_mismatch("kind", want.kind, rsp_kind);
               if (rsp_sample_bits_res !== want.smp)
                  report_mismatch("sample", want.smp, rsp_sample_bits_res);
               if (rsp_last !== want.last) report_mismatch("last", want.last, rsp_last);
               if (rsp_peak_bits !== want.peak)
                  report_mismatch("peak", want.peak, rsp_peak_bits);
               if (rsp_frames_total !== want.frames)
                  report_mismatch("frames", want.frames, rsp_frames_total);
               if (rsp_overrun_count !== want.ovr)
                  report_mismatch("overruns", want.ovr, rsp_overrun_count);
            end
         end
         if (csr_we) apply_csr(csr_index, csr_wdata);
         if (start && !busy) begin
            capture_step(req_action, req_frame_count, req_sample_bits, req_max_count,
                         req_channel);
            if (typed_pend) pending_results.push_back(typed_want);
            else foreach (step_results[i]) pending_results.push_back(step_results[i]);
         end
         idle_cycles <= (rsp_valid || csr_we || (start && !busy)) ? 0 : idle_cycles + 1;
      end
   end

   initial begin
      while (idle_cycles < WATCHDOG_CYCLES) @(posedge clock);
      $display("audio_capture_ring_buffer_top verification failed");
      $finish;
   end

   task automatic send_word(input logic [2:0] act, input logic [12:0] fc,
                            input logic [31:0] bits, input logic [6:0] mc,
                            input logic [4:0] ch, input bit typed = 1'b0,
                            input capture_result_t want = '0);
      start <= 1'b1;
      req_action <= act;
      req_frame_count <= fc;
      req_sample_bits <= bits;
      req_max_count <= mc;
      req_channel <= ch;
      typed_pend <= typed;
      typed_want <= want;
      do @(posedge clock); while (busy);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         start <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(0, 12);
      end
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [0:0] idx, input logic [16:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] pick_sample();
      logic [31:0] v;
      v = $urandom;
      case ($urandom_range(0, 9))
         0: v = {v[31], INF_BITS};
         1: v = {v[31], 8'hFF, v[22:0] | 23'd1};   // NaN
         2: v = {v[31], 31'd0};
         3: v = {v[31], 31'h7F7F_FFFF};
         4: v = {v[31], 23'd0, v[7:0]};
         default: ;
      endcase
      return v;
   endfunction

   task automatic run_traffic(input int n_items, input int unsigned pop_weight);
      int done;
      int unsigned r, k, nf, ns;
      logic [6:0] mc;
      done = 0;
      while (done < n_items) begin
         r = $urandom_range(0, 99);
         if (r < 50) begin
            k = $urandom_range(0, 19);
            if (k == 0) nf = $urandom_range(MAX_FRAMES + 1, 8191);
            else if (k == 1) nf = $urandom_range(0, MAX_FRAMES);
            else nf = $urandom_range(0, 48 / chan_count + 1);
            send_word(ACT_BEGIN, nf, $urandom, $urandom, $urandom);
            done++;
            ns = (k <= 1) ? $urandom_range(0, 3) : nf * chan_count;
            if ($urandom_range(0, 9) == 0) ns = $urandom_range(0, ns);
            repeat (ns) begin
               send_word(ACT_SAMPLE, $urandom, pick_sample(), $urandom, $urandom);
               done++;
            end
            if ($urandom_range(0, 19) == 0)
               send_word(ACT_SAMPLE, $urandom, pick_sample(), $urandom, $urandom);
         end else if (r < 50 + pop_weight) begin
            k = $urandom_range(0, 9);
            if (k == 0) mc = 7'd0;
            else if (k == 1) mc = $urandom_range(MAX_POP + 1, 127);
            else mc = $urandom_range(1, MAX_POP);
            send_word(ACT_POP, $urandom, $urandom, mc, $urandom);
            done++;
         end else if (r < 90) begin
            send_word(ACT_PEAK, $urandom, $urandom, $urandom,
                      $urandom_range(0, 1) ? $urandom_range(0, 31)
                                           : $urandom_range(0, chan_count - 1));
            done++;
         end else if (r < 96) begin
            send_word(ACT_STATUS, $urandom, $urandom, $urandom, $urandom);
            done++;
         end else begin
            send_word($urandom_range(ACT_RESERVED_LO, ACT_RESERVED_HI), $urandom, $urandom,
                      $urandom, $urandom);
         end
      end
   endtask

   initial begin
      capture_result_t want;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_tab[i]) begin
         want = '0;
         want.kind = dir_tab[i].wkind;
         want.last = 1'b1;
         want.peak = dir_tab[i].wpeak;
         want.frames = dir_tab[i].wframes;
         want.ovr = dir_tab[i].wovr;
         send_word(dir_tab[i].action, dir_tab[i].frames, dir_tab[i].bits,
                   dir_tab[i].max_count, dir_tab[i].chan, dir_tab[i].typed, want);
      end
      wait_idle();

      // channel count change while a block is open keeps its remaining samples
      send_word(ACT_BEGIN, 13'd3, '0, '0, '0);
      repeat (2) send_word(ACT_SAMPLE, '0, pick_sample(), '0, '0);
      wait_idle();
      write_reg(CSR_CHANNELS, 17'd3);
      repeat (4) send_word(ACT_SAMPLE, '0, pick_sample(), '0, '0);
      send_word(ACT_POP, '0, '0, 7'd64, '0);
      send_word(ACT_PEAK, '0, '0, '0, 5'd2);
      send_word(ACT_STATUS, '0, '0, '0, '0);
      wait_idle();

      for (int p = 0; p < 6; p++) begin
         write_reg(CSR_CHANNELS, phase_chans[p]);
         write_reg(CSR_RING_SIZE, phase_ring[p]);
         run_traffic(65, phase_pop[p]);
         wait_idle();
      end

      // pile up rejected blocks past the overrun counter's ceiling
      write_reg(CSR_CHANNELS, 17'd1);
      write_reg(CSR_RING_SIZE, 17'd1);
      repeat (OVR_SAT + 5) send_word(ACT_BEGIN, MAX_FRAMES, $urandom, $urandom, $urandom);
      send_word(ACT_STATUS, '0, '0, '0, '0);
      send_word(ACT_POP, '0, '0, 7'd64, '0);
      wait_idle();

      if (mismatches == 0)
         $display("audio_capture_ring_buffer_top verification clean");
      else
         $display("audio_capture_ring_buffer_top verification failed");
      $finish;
   end

endmodule
